FILE: src/matrix_rain_cell_generator_assert.svh
// Assertion macros used by the rain cell generator checker.
`ifndef MATRIX_RAIN_CELL_GENERATOR_ASSERT_SVH
`define MATRIX_RAIN_CELL_GENERATOR_ASSERT_SVH
// Same-cycle implication, disabled while reset is asserted.
`define MRC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rain cell generator check failed");
// Next-cycle implication, disabled while reset is asserted.
`define MRC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rain cell generator check failed");
`endif

FILE: src/mrc_pkg.sv
// Shared constants, types and functions of the rain cell generator.
package mrc_pkg;

  localparam int unsigned TRAIL_LENGTH_DEF = 6;
  localparam int unsigned PIPE_DEPTH = 15;
  localparam int unsigned MOD_STAGES = 4;
  localparam int unsigned DIGIT_W = 8;
  localparam int unsigned LVL_W = 4;

  localparam logic [31:0] COL_MULT = 32'd2654435761;
  localparam logic [31:0] MIX_C1 = 32'h7feb352d;
  localparam logic [31:0] MIX_C2 = 32'h846ca68b;
  localparam logic [31:0] GLY_COL_MULT = 32'd131;
  localparam logic [31:0] GLY_ROW_MULT = 32'd977;

  localparam logic [7:0] VROWS_RESET = 8'd40;
  localparam logic [15:0] THEME_RESET = 16'd2016;

  localparam logic REG_VIRTUAL_ROWS = 1'b0;
  localparam logic REG_THEME_COLOR = 1'b1;

  localparam logic [2:0] SHADE_DIV2 = 3'd0;
  localparam logic [2:0] SHADE_DIV3 = 3'd1;
  localparam logic [2:0] SHADE_DIV5 = 3'd2;
  localparam logic [2:0] SHADE_DIV8 = 3'd3;
  localparam logic [2:0] SHADE_DIV12 = 3'd4;

  typedef struct packed {
    logic [7:0]  row;
    logic [31:0] frame;
    logic        spd;
    logic        glyph;
    logic        dark;
  } side_t;

  // One remainder digit step: shifts in eight bits, each with a conditional subtract.
  function automatic logic [7:0] mod_step8(logic [7:0] r, logic [7:0] bits, logic [7:0] m);
    logic [8:0] t;
    logic [7:0] acc;
    acc = r;
    for (int i = DIGIT_W - 1; i >= 0; i--) begin
      t = {acc, bits[i]};
      if (t >= {1'b0, m}) begin
        t = t - {1'b0, m};
      end
      acc = t[7:0];
    end
    return acc;
  endfunction

  function automatic logic [31:0] mix_fold16(logic [31:0] x);
    return x ^ (x >> 16);
  endfunction

  function automatic logic [31:0] mix_fold15(logic [31:0] x);
    return x ^ (x >> 15);
  endfunction

  // Channel divide by 2, 3, 5, 8 or 12 through reciprocal multiplication.
  function automatic logic [5:0] div_ch(logic [5:0] x, logic [2:0] sel);
    logic [13:0] p;
    logic [5:0]  q;
    p = 14'd0;
    unique case (sel)
      SHADE_DIV2: q = x >> 1;
      SHADE_DIV3: begin
        p = {8'd0, x} * 14'd43;
        q = 6'(p >> 7);
      end
      SHADE_DIV5: begin
        p = {8'd0, x} * 14'd205;
        q = 6'(p >> 10);
      end
      SHADE_DIV8: q = x >> 3;
      default: begin
        p = {8'd0, x} * 14'd171;
        q = 6'(p >> 11);
      end
    endcase
    return q;
  endfunction

  function automatic logic [15:0] shade565(logic [15:0] c, logic [2:0] sel);
    logic [5:0] r;
    logic [5:0] g;
    logic [5:0] b;
    r = div_ch({1'b0, c[15:11]}, sel);
    g = div_ch(c[10:5], sel);
    b = div_ch({1'b0, c[4:0]}, sel);
    return {r[4:0], g, b[4:0]};
  endfunction

endpackage

FILE: src/matrix_rain_cell_generator.sv
// Top level of the falling-glyph rain cell generator.
// Cells enter on the in_valid_i/in_ready_o channel (column, row, frame) and
// results leave on out_valid_o/out_ready_i (lit, trail level, glyph, color).
// Each beat passes through a 15-stage pipeline: four stages of column and
// glyph hashing, four stages taking the column phase modulo virtual_rows,
// one stage forming frame times speed plus phase, four stages reducing it
// modulo virtual_rows, one stage deciding the trail level and one output
// stage that dims the theme color. One beat is accepted every cycle while
// the receiver does not stall; the depth is set by the two 32-bit hash
// multipliers and the byte-per-stage remainder units.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready_o falls; no beat is lost or repeated.
// Reset empties the pipeline and sets virtual_rows to 40 and theme_color
// to 2016. Configuration writes take effect at once; the user must make them
// only while the pipeline is empty, and the block itself does not enforce this.
module matrix_rain_cell_generator #(
  parameter int unsigned TRAIL_LENGTH = mrc_pkg::TRAIL_LENGTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  column_i,
  input  logic [7:0]  cell_row_i,
  input  logic [31:0] frame_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        lit_o,
  output logic [2:0]  trail_level_o,
  output logic        glyph_bit_o,
  output logic [15:0] pixel_color_o
);

  localparam int unsigned SIDE_N = 13;
  localparam int unsigned HASH_TAP = 4;

  logic [7:0]  vrows_q;
  logic [15:0] theme_q;
  logic [mrc_pkg::PIPE_DEPTH-1:0] v_q;
  logic        en;

  logic [31:0] col_x;
  logic [31:0] gly_x;
  logic [31:0] hc;
  logic [31:0] gh;
  logic [7:0]  phase;
  logic [7:0]  head;
  logic [31:0] w_q;
  mrc_pkg::side_t side_q [SIDE_N];
  mrc_pkg::side_t side_tap;

  logic        lit_d;
  logic [7:0]  diff;
  logic        lit_q;
  logic        glyph_q;
  logic [mrc_pkg::LVL_W-1:0] lvl_q;
  logic [2:0]  sel;

  assign en = !v_q[mrc_pkg::PIPE_DEPTH-1] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vrows_q <= mrc_pkg::VROWS_RESET;
      theme_q <= mrc_pkg::THEME_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        mrc_pkg::REG_VIRTUAL_ROWS: vrows_q <= cfg_data_i[7:0];
        default: theme_q <= cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[mrc_pkg::PIPE_DEPTH-2:0], in_valid_i};
    end
  end

  assign col_x = {24'd0, column_i} * mrc_pkg::COL_MULT + 32'd1;
  assign gly_x = {24'd0, column_i} * mrc_pkg::GLY_COL_MULT
               + {24'd0, cell_row_i} * mrc_pkg::GLY_ROW_MULT + (frame_i >> 3);

  mrc_hash u_col_hash (.clk_i(clk_i), .en_i(en), .x_i(col_x), .h_o(hc));
  mrc_hash u_gly_hash (.clk_i(clk_i), .en_i(en), .x_i(gly_x), .h_o(gh));

  mrc_mod u_phase_mod (.clk_i(clk_i), .en_i(en), .x_i(hc), .m_i(vrows_q), .r_o(phase));
  mrc_mod u_head_mod (.clk_i(clk_i), .en_i(en), .x_i(w_q), .m_i(vrows_q), .r_o(head));

  always_comb begin
    side_tap       = side_q[HASH_TAP-1];
    side_tap.spd   = hc[5];
    side_tap.glyph = gh[0];
    side_tap.dark  = (hc[1:0] == 2'd0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= '{row: cell_row_i, frame: frame_i, spd: 1'b0, glyph: 1'b0, dark: 1'b0};
      for (int k = 1; k < SIDE_N; k++) begin
        side_q[k] <= (k == HASH_TAP) ? side_tap : side_q[k-1];
      end
      w_q <= (side_q[7].spd ? {side_q[7].frame[30:0], 1'b0} : side_q[7].frame)
           + {24'd0, phase};
    end
  end

  assign diff  = head - side_q[SIDE_N-1].row;
  assign lit_d = !side_q[SIDE_N-1].dark && (vrows_q != 8'd0)
              && (head >= side_q[SIDE_N-1].row) && (diff < 8'(TRAIL_LENGTH));

  always_ff @(posedge clk_i) begin
    if (en) begin
      lit_q   <= lit_d;
      glyph_q <= side_q[SIDE_N-1].glyph;
      lvl_q   <= diff[mrc_pkg::LVL_W-1:0];
    end
  end

  assign sel = (lvl_q < 4'd4) ? lvl_q[2:0] : mrc_pkg::SHADE_DIV12;

  always_ff @(posedge clk_i) begin
    if (en) begin
      lit_o         <= lit_q;
      trail_level_o <= lit_q ? lvl_q[2:0] : 3'd0;
      glyph_bit_o   <= lit_q && glyph_q;
      pixel_color_o <= lit_q ? mrc_pkg::shade565(theme_q, sel) : 16'd0;
    end
  end

  assign out_valid_o = v_q[mrc_pkg::PIPE_DEPTH-1];

endmodule

FILE: src/mrc_hash.sv
// Four-stage 32-bit mixing hash with a multiplier in the second and third stages.
module mrc_hash (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] x_i,
  output logic [31:0] h_o
);

  logic [31:0] x_q;
  logic [31:0] m1_q;
  logic [31:0] m2_q;
  logic [31:0] h_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q  <= x_i;
      m1_q <= mrc_pkg::mix_fold16(x_q) * mrc_pkg::MIX_C1;
      m2_q <= mrc_pkg::mix_fold15(m1_q) * mrc_pkg::MIX_C2;
      h_q  <= mrc_pkg::mix_fold16(m2_q);
    end
  end

  assign h_o = h_q;

endmodule

FILE: src/mrc_mod.sv
// Pipelined remainder of a 32-bit value by an 8-bit modulus, one byte per stage.
module mrc_mod (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] x_i,
  input  logic [7:0]  m_i,
  output logic [7:0]  r_o
);

  logic [7:0]  r_q [mrc_pkg::MOD_STAGES];
  logic [31:0] x_q [mrc_pkg::MOD_STAGES];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0] <= mrc_pkg::mod_step8(8'd0, x_i[31:24], m_i);
      x_q[0] <= x_i;
      for (int k = 1; k < mrc_pkg::MOD_STAGES; k++) begin
        r_q[k] <= mrc_pkg::mod_step8(r_q[k-1], x_q[k-1][31-8*k -: 8], m_i);
        x_q[k] <= x_q[k-1];
      end
    end
  end

  assign r_o = r_q[mrc_pkg::MOD_STAGES-1];

endmodule

FILE: src/mrc_checker.sv
// Port-level checker for the rain cell generator, bound to the top level.
`include "matrix_rain_cell_generator_assert.svh"
module mrc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic        cfg_index_i,
  input logic [15:0] cfg_data_i,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [7:0]  column_i,
  input logic [7:0]  cell_row_i,
  input logic [31:0] frame_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        lit_o,
  input logic [2:0]  trail_level_o,
  input logic        glyph_bit_o,
  input logic [15:0] pixel_color_o
);

  `MRC_ASSERT_IMPLY(a_dark_zero, clk_i, rst_ni, out_valid_o && !lit_o,
    trail_level_o == 3'd0 && !glyph_bit_o && pixel_color_o == 16'd0)

  `MRC_ASSERT_IMPLY(a_ready_when_empty, clk_i, rst_ni, !out_valid_o, in_ready_o)

  `MRC_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(lit_o) && $stable(trail_level_o) && $stable(pixel_color_o))

endmodule

bind matrix_rain_cell_generator mrc_checker u_mrc_checker (.*);
